// ===== rtl/cmm_pkg.sv =====
// cmm_pkg: shared types, constants and helpers for the channel mask manager
// depends on nothing; imported by cmm_band_unit, channel_mask_manager and the testbench
`timescale 1ns / 1ps

package cmm_pkg;

   // subbands in the band plan (numbered 0 to 7)
   localparam int SUBBANDS = 8;

   localparam logic [7:0] NUM_CHANNELS   = 8'd72;
   localparam logic [6:0] NARROW_RESET   = 7'd64;
   localparam logic [3:0] WIDE_RESET     = 4'd8;
   localparam logic [7:0] BAND_LIMIT     = 8'(SUBBANDS);
   localparam logic [2:0] LAST_BAND      = 3'(SUBBANDS - 1);

   // action codes
   localparam logic [2:0] ACT_ENABLE_CH  = 3'd0;
   localparam logic [2:0] ACT_DISABLE_CH = 3'd1;
   localparam logic [2:0] ACT_ENABLE_SB  = 3'd2;
   localparam logic [2:0] ACT_DISABLE_SB = 3'd3;
   localparam logic [2:0] ACT_SELECT_SB  = 3'd4;

   // one step of the shared band unit
   typedef struct packed {
      logic       en;
      logic [7:0] nmask;
      logic [7:0] wmask;
   } step_cmd_type;

   typedef struct packed {
      logic [7:0] new_byte;
      logic [7:0] new_wide;
      logic       changed;
      logic [6:0] narrow_next;
      logic [3:0] wide_next;
   } step_res_type;

   function automatic logic [3:0] popcount8(input logic [7:0] v);
      logic [3:0] n;
      n = 4'd0;
      for (int i = 0; i < 8; i++) begin
         n = n + 4'(v[i]);
      end
      return n;
   endfunction

endpackage

// ===== rtl/cmm_band_unit.sv =====
// cmm_band_unit: shared update unit, applies one enable/disable step to one
// mask byte and the 500 kHz bits and adjusts both counts; uses cmm_pkg
`timescale 1ns / 1ps

module cmm_band_unit import cmm_pkg::*; (
   input  step_cmd_type cmd,
   input  logic [7:0]   old_byte,
   input  logic [7:0]   old_wide,
   input  logic [6:0]   narrow_count,
   input  logic [3:0]   wide_count,
   output step_res_type res
);

   logic [7:0] flip_n;
   logic [7:0] flip_w;
   logic [3:0] pc_n;
   logic [3:0] pc_w;

   // bits that actually toggle
   assign flip_n = cmd.en ? (cmd.nmask & ~old_byte) : (cmd.nmask & old_byte);
   assign flip_w = cmd.en ? (cmd.wmask & ~old_wide) : (cmd.wmask & old_wide);
   assign pc_n   = popcount8(flip_n);
   assign pc_w   = popcount8(flip_w);

   always_comb begin
      res.new_byte    = old_byte ^ flip_n;
      res.new_wide    = old_wide ^ flip_w;
      res.changed     = (|flip_n) | (|flip_w);
      res.narrow_next = cmd.en ? (narrow_count + 7'(pc_n)) : (narrow_count - 7'(pc_n));
      res.wide_next   = cmd.en ? (wide_count + pc_w) : (wide_count - pc_w);
   end

endmodule

// ===== rtl/channel_mask_manager.sv =====
// channel_mask_manager: top level, 72-channel uplink enable mask with counts
// depends on cmm_pkg and cmm_band_unit
`timescale 1ns / 1ps

// usage
// - request channel (req_*): one transaction names an action and a target
//   (channel number, or subband number); accepted when req_valid and req_ready
// - response channel (rsp_*): one transaction per request with the changed
//   flag, the bad band flag and the enabled channel counts after the action
// - the block handles one request at a time; req_ready is high only while idle
// - band-unit steps from request to response valid:
//     channel action, enable or disable subband: one step
//     select subband: one step per subband
//     ignored channel, bad band or unknown action: none, straight to the response
//   each step runs one byte of the mask through the shared band unit
// - after the response is taken the block returns to idle, and only there
//   does it accept the next request
// - a stalled response (rsp_ready low) simply holds; no new request is taken
//   until the response is delivered
// - reset enables every channel: counts read 64 narrow and 8 wide, no
//   response pending, block ready in the first cycle after reset

module channel_mask_manager import cmm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_action,
   input  logic [7:0] req_target,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_changed,
   output logic       rsp_bad_band,
   output logic [6:0] rsp_count_narrow,
   output logic [3:0] rsp_count_wide
);

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_type;

   state_type    state_ff, state_in;
   logic         en_ff, en_in;
   logic         select_ff, select_in;
   logic [2:0]   band_ff, band_in;
   logic [2:0]   sel_band_ff, sel_band_in;
   logic [7:0]   nmask_ff, nmask_in;
   logic [7:0]   wmask_ff, wmask_in;
   logic         changed_ff, changed_in;
   logic         bad_ff, bad_in;
   logic [7:0]   narrow_mask_ff [8];
   logic [7:0]   narrow_mask_in [8];
   logic [7:0]   wide_mask_ff, wide_mask_in;
   logic [6:0]   narrow_count_ff, narrow_count_in;
   logic [3:0]   wide_count_ff, wide_count_in;

   step_cmd_type cmd;
   step_res_type res;

   // the step command comes straight from the sequencer registers
   always_comb begin
      cmd.en    = select_ff ? (band_ff == sel_band_ff) : en_ff;
      cmd.nmask = nmask_ff;
      cmd.wmask = select_ff ? (8'd1 << band_ff) : wmask_ff;
   end

   cmm_band_unit u_band (
      .cmd          (cmd),
      .old_byte     (narrow_mask_ff[band_ff]),
      .old_wide     (wide_mask_ff),
      .narrow_count (narrow_count_ff),
      .wide_count   (wide_count_ff),
      .res          (res)
   );

   always_comb begin
      state_in        = state_ff;
      en_in           = en_ff;
      select_in       = select_ff;
      band_in         = band_ff;
      sel_band_in     = sel_band_ff;
      nmask_in        = nmask_ff;
      wmask_in        = wmask_ff;
      changed_in      = changed_ff;
      bad_in          = bad_ff;
      narrow_mask_in  = narrow_mask_ff;
      wide_mask_in    = wide_mask_ff;
      narrow_count_in = narrow_count_ff;
      wide_count_in   = wide_count_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               changed_in  = 1'b0;
               bad_in      = 1'b0;
               select_in   = 1'b0;
               sel_band_in = req_target[2:0];
               band_in     = 3'd0;
               nmask_in    = 8'd0;
               wmask_in    = 8'd0;
               case (req_action)
                  ACT_ENABLE_CH, ACT_DISABLE_CH: begin
                     en_in = (req_action == ACT_ENABLE_CH);
                     if (req_target[7:6] == 2'b00) begin
                        // 125 kHz channel: one bit of one byte
                        band_in  = req_target[5:3];
                        nmask_in = 8'd1 << req_target[2:0];
                        state_in = ST_RUN;
                     end else if (req_target < NUM_CHANNELS) begin
                        // 500 kHz channel
                        wmask_in = 8'd1 << req_target[2:0];
                        state_in = ST_RUN;
                     end else begin
                        // channel out of range, ignored
                        state_in = ST_DONE;
                     end
                  end
                  ACT_ENABLE_SB, ACT_DISABLE_SB, ACT_SELECT_SB: begin
                     en_in = (req_action == ACT_ENABLE_SB);
                     if (req_target >= BAND_LIMIT) begin
                        bad_in   = 1'b1;
                        state_in = ST_DONE;
                     end else begin
                        nmask_in  = 8'hFF;
                        wmask_in  = 8'd1 << req_target[2:0];
                        select_in = (req_action == ACT_SELECT_SB);
                        band_in   = (req_action == ACT_SELECT_SB) ? 3'd0 : req_target[2:0];
                        state_in  = ST_RUN;
                     end
                  end
                  default: begin
                     // unknown action, ignored
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_RUN: begin
            // commit one band-unit step
            narrow_mask_in[band_ff] = res.new_byte;
            wide_mask_in            = res.new_wide;
            narrow_count_in         = res.narrow_next;
            wide_count_in           = res.wide_next;
            changed_in              = changed_ff | res.changed;
            if (select_ff && (band_ff != LAST_BAND)) begin
               band_in = band_ff + 3'd1;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         narrow_mask_ff  <= '{default: 8'hFF};
         wide_mask_ff    <= 8'hFF;
         narrow_count_ff <= NARROW_RESET;
         wide_count_ff   <= WIDE_RESET;
      end else begin
         state_ff        <= state_in;
         narrow_mask_ff  <= narrow_mask_in;
         wide_mask_ff    <= wide_mask_in;
         narrow_count_ff <= narrow_count_in;
         wide_count_ff   <= wide_count_in;
      end
      // sequencer payload, no reset needed
      en_ff       <= en_in;
      select_ff   <= select_in;
      band_ff     <= band_in;
      sel_band_ff <= sel_band_in;
      nmask_ff    <= nmask_in;
      wmask_ff    <= wmask_in;
      changed_ff  <= changed_in;
      bad_ff      <= bad_in;
   end

   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = (state_ff == ST_DONE);
   assign rsp_changed      = changed_ff;
   assign rsp_bad_band     = bad_ff;
   assign rsp_count_narrow = narrow_count_ff;
   assign rsp_count_wide   = wide_count_ff;

   // population of the narrow mask, checked against the running count
   logic [6:0] narrow_pop;
   always_comb begin
      narrow_pop = 7'd0;
      for (int i = 0; i < 8; i++) begin
         narrow_pop = narrow_pop + 7'(popcount8(narrow_mask_ff[i]));
      end
   end

   // running counts track the mask
   a_counts_match: assert property (@(posedge clock) disable iff (reset)
      (narrow_count_ff == narrow_pop) && (wide_count_ff == popcount8(wide_mask_ff)))
      else $error("channel counts disagree with the enable mask");

   // wide mask and narrow count only move while a step is running
   a_mask_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_RUN) |=> ($stable(wide_mask_ff) && $stable(narrow_count_ff)))
      else $error("mask changed outside a running step");

   // bad band goes straight to the response with nothing changed
   a_bad_band: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_target >= BAND_LIMIT) &&
       ((req_action == ACT_ENABLE_SB) || (req_action == ACT_DISABLE_SB) ||
        (req_action == ACT_SELECT_SB)))
      |=> (rsp_valid && rsp_bad_band && !rsp_changed))
      else $error("bad band transaction not flagged");

   // a non-final select step keeps the sequencer running
   a_select_runs: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_RUN) && select_ff && (band_ff != LAST_BAND))
      |=> ((state_ff == ST_RUN) && (band_ff == $past(band_ff) + 3'd1)))
      else $error("select sequence ended early");

endmodule

// ===== test/testbench.sv =====
// testbench: self-checking bench for channel_mask_manager, directed rows then random
// depends on cmm_pkg and channel_mask_manager; checked against typed rows and a mask model
`timescale 1ns / 1ps

module testbench;
   import cmm_pkg::*;

   // action codes the block does not define, all of them ignored
   localparam logic [2:0] ACT_RESERVED_5 = 3'd5;
   localparam logic [2:0] ACT_RESERVED_6 = 3'd6;
   localparam logic [2:0] ACT_RESERVED_7 = 3'd7;

   localparam int NARROW_CHANNELS = 64;
   localparam int DIRECTED_ROWS   = 25;
   localparam int RANDOM_ITEMS    = 525;

   // one response transaction, field for field
   typedef struct packed {
      logic       changed;
      logic       bad_band;
      logic [6:0] count_narrow;
      logic [3:0] count_wide;
   } outcome_type;

   // one row of the directed table; want is only used when typed is set
   typedef struct packed {
      logic [2:0]  act;
      logic [7:0]  tgt;
      logic        typed;
      outcome_type want;
   } stim_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [2:0] req_action = ACT_ENABLE_CH;
   logic [7:0] req_target = 8'd0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_changed;
   logic       rsp_bad_band;
   logic [6:0] rsp_count_narrow;
   logic [3:0] rsp_count_wide;

   // while set, neither side inserts idle cycles
   logic no_idle = 1'b0;

   // model of the enable mask and its two running counts
   logic [71:0] mask_model;
   logic [6:0]  narrow_model;
   logic [3:0]  wide_model;

   // responses still owed by the block, oldest first
   outcome_type pending_outcomes[$];

   int error_count    = 0;
   int sent_count     = 0;
   int ignored_count  = 0;
   int checked_count  = 0;
   int bad_band_count = 0;
   int changed_count  = 0;
   int narrow_low     = 64;
   int narrow_high    = 0;
   int wide_low       = 8;
   int wide_high      = 0;

   stim_row_type directed_rows [DIRECTED_ROWS];

   channel_mask_manager u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_target       (req_target),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_changed      (rsp_changed),
      .rsp_bad_band     (rsp_bad_band),
      .rsp_count_narrow (rsp_count_narrow),
      .rsp_count_wide   (rsp_count_wide)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // generous time ceiling for all directed and random requests
   initial begin
      #2_000_000;
      $display("testbench: done, errors");
      $finish;
   end

   // ------------------------------------------------------------------
   // mask model
   // ------------------------------------------------------------------

   // write one channel's enable bit, keep the counts in step, report a flip
   function automatic logic write_channel(input int ch, input logic en);
      if (ch >= int'(NUM_CHANNELS)) return 1'b0;
      if (mask_model[ch] == en) return 1'b0;
      mask_model[ch] = en;
      if (ch < NARROW_CHANNELS) begin
         narrow_model = en ? narrow_model + 7'd1 : narrow_model - 7'd1;
      end else begin
         wide_model = en ? wide_model + 4'd1 : wide_model - 4'd1;
      end
      return 1'b1;
   endfunction

   // a subband is its eight 125 kHz channels plus 500 kHz channel 64+band
   function automatic logic write_subband(input int band, input logic en);
      logic flipped;
      flipped = 1'b0;
      for (int i = 0; i < 8; i++) begin
         flipped |= write_channel(band * 8 + i, en);
      end
      flipped |= write_channel(NARROW_CHANNELS + band, en);
      return flipped;
   endfunction

   // apply one request to the model and return the response it must produce
   function automatic outcome_type apply_mask_action(input logic [2:0] act,
                                                     input logic [7:0] tgt);
      outcome_type r;
      r = '0;
      case (act)
         ACT_ENABLE_CH:  r.changed = write_channel(int'(tgt), 1'b1);
         ACT_DISABLE_CH: r.changed = write_channel(int'(tgt), 1'b0);
         ACT_ENABLE_SB, ACT_DISABLE_SB, ACT_SELECT_SB: begin
            if (tgt >= BAND_LIMIT) begin
               r.bad_band = 1'b1;
            end else if (act == ACT_ENABLE_SB) begin
               r.changed = write_subband(int'(tgt), 1'b1);
            end else if (act == ACT_DISABLE_SB) begin
               r.changed = write_subband(int'(tgt), 1'b0);
            end else begin
               for (int b = 0; b < SUBBANDS; b++) begin
                  r.changed |= write_subband(b, b == int'(tgt));
               end
            end
         end
         default: ;
      endcase
      r.count_narrow = narrow_model;
      r.count_wide   = wide_model;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------

   // called right after a rising edge; returns right after the edge that took the transaction.
   // valid is left high so a back-to-back request keeps it high without a dip
   task automatic send_request(input logic [2:0] act, input logic [7:0] tgt,
                               input logic typed, input outcome_type typed_want);
      outcome_type model_want;
      while (!no_idle && $urandom_range(0, 99) < 9) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_action <= act;
      req_target <= tgt;
      // the model runs for every request so its state stays in step with the rtl
      model_want = apply_mask_action(act, tgt);
      pending_outcomes.push_back(typed ? typed_want : model_want);
      sent_count++;
      do @(posedge clock); while (!req_ready);
   endtask

   // ------------------------------------------------------------------
   // response side
   // ------------------------------------------------------------------

   // ready is dropped at random about 9 percent of the time, except during the quiet stretch
   always @(posedge clock) begin
      rsp_ready <= no_idle || ($urandom_range(0, 99) >= 9);
   end

   // every accepted response is matched against the oldest expectation
   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_outcomes.size() == 0) begin
            $error("response with nothing outstanding: changed %0d bad_band %0d",
                   rsp_changed, rsp_bad_band);
            error_count++;
         end else begin
            want = pending_outcomes.pop_front();
            checked_count++;
            if (rsp_changed !== want.changed) begin
               $error("rsp_changed: expected %0d, got %0d", want.changed, rsp_changed);
               error_count++;
            end
            if (rsp_bad_band !== want.bad_band) begin
               $error("rsp_bad_band: expected %0d, got %0d", want.bad_band, rsp_bad_band);
               error_count++;
            end
            if (rsp_count_narrow !== want.count_narrow) begin
               $error("rsp_count_narrow: expected %0d, got %0d",
                      want.count_narrow, rsp_count_narrow);
               error_count++;
            end
            if (rsp_count_wide !== want.count_wide) begin
               $error("rsp_count_wide: expected %0d, got %0d", want.count_wide, rsp_count_wide);
               error_count++;
            end
            if (want.bad_band) bad_band_count++;
            if (want.changed) changed_count++;
            if (int'(want.count_narrow) < narrow_low) narrow_low = int'(want.count_narrow);
            if (int'(want.count_narrow) > narrow_high) narrow_high = int'(want.count_narrow);
            if (int'(want.count_wide) < wide_low) wide_low = int'(want.count_wide);
            if (int'(want.count_wide) > wide_high) wide_high = int'(want.count_wide);
         end
      end
   end

   // ------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------

   initial begin
      int         n;
      int         pick;
      int         lean_off;
      logic [2:0] act;
      logic [7:0] tgt;

      // after reset every channel is on: 64 narrow, 8 wide
      mask_model   = '1;
      narrow_model = 7'd64;
      wide_model   = 4'd8;

      // typed rows cover reset state, the edges of each field and the error flag;
      // the rest lean on the model
      directed_rows = '{
         // enabling an enabled channel changes nothing
         '{ACT_ENABLE_CH,  8'd0,   1'b1, '{1'b0, 1'b0, 7'd64, 4'd8}},
         '{ACT_DISABLE_CH, 8'd0,   1'b1, '{1'b1, 1'b0, 7'd63, 4'd8}},
         // top 500 kHz channel
         '{ACT_DISABLE_CH, 8'd71,  1'b1, '{1'b1, 1'b0, 7'd63, 4'd7}},
         '{ACT_DISABLE_CH, 8'd71,  1'b1, '{1'b0, 1'b0, 7'd63, 4'd7}},
         // channel number past the plan is ignored
         '{ACT_DISABLE_CH, 8'd72,  1'b1, '{1'b0, 1'b0, 7'd63, 4'd7}},
         '{ACT_ENABLE_CH,  8'd255, 1'b1, '{1'b0, 1'b0, 7'd63, 4'd7}},
         // undefined actions are ignored
         '{ACT_RESERVED_5, 8'd0,   1'b1, '{1'b0, 1'b0, 7'd63, 4'd7}},
         '{ACT_RESERVED_7, 8'd255, 1'b1, '{1'b0, 1'b0, 7'd63, 4'd7}},
         // band past the plan: error flag, mask untouched
         '{ACT_ENABLE_SB,  8'd8,   1'b1, '{1'b0, 1'b1, 7'd63, 4'd7}},
         '{ACT_DISABLE_SB, 8'd255, 1'b1, '{1'b0, 1'b1, 7'd63, 4'd7}},
         '{ACT_SELECT_SB,  8'd128, 1'b1, '{1'b0, 1'b1, 7'd63, 4'd7}},
         '{ACT_ENABLE_SB,  8'd0,   1'b0, '0},
         '{ACT_SELECT_SB,  8'd7,   1'b0, '0},
         // selecting the band already selected flips nothing
         '{ACT_SELECT_SB,  8'd7,   1'b0, '0},
         // both counts down to zero
         '{ACT_DISABLE_SB, 8'd7,   1'b0, '0},
         '{ACT_DISABLE_SB, 8'd7,   1'b0, '0},
         '{ACT_ENABLE_CH,  8'd63,  1'b0, '0},
         '{ACT_ENABLE_CH,  8'd64,  1'b0, '0},
         '{ACT_ENABLE_CH,  8'd71,  1'b0, '0},
         '{ACT_SELECT_SB,  8'd0,   1'b0, '0},
         '{ACT_ENABLE_SB,  8'd7,   1'b0, '0},
         '{ACT_DISABLE_CH, 8'd70,  1'b0, '0},
         '{ACT_RESERVED_6, 8'd170, 1'b0, '0},
         '{ACT_ENABLE_SB,  8'd3,   1'b0, '0},
         '{ACT_DISABLE_SB, 8'd3,   1'b0, '0}
      };

      // reset held at the start, then released once for good
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         send_request(directed_rows[i].act, directed_rows[i].tgt,
                      directed_rows[i].typed, directed_rows[i].want);
      end

      // random part: stretches that lean toward enabling alternate with ones that
      // lean toward disabling, so the counts sweep from full to empty and back
      n = 0;
      while (n < RANDOM_ITEMS) begin
         // a long run with no idle cycles on either side
         no_idle <= (n >= 150 && n < 280);
         lean_off = ((n / 40) % 2 == 1) ? 70 : 30;
         pick = $urandom_range(0, 99);
         if (pick < 6) begin
            // undefined action with any target
            case ($urandom_range(0, 2))
               0:       act = ACT_RESERVED_5;
               1:       act = ACT_RESERVED_6;
               default: act = ACT_RESERVED_7;
            endcase
            tgt = 8'($urandom_range(0, 255));
         end else if (pick < 56) begin
            // single channel, mostly inside the plan
            act = ($urandom_range(0, 99) < lean_off) ? ACT_DISABLE_CH : ACT_ENABLE_CH;
            tgt = ($urandom_range(0, 99) < 90) ? 8'($urandom_range(0, 71))
                                               : 8'($urandom_range(72, 255));
         end else begin
            // subband, mostly a real one; select now and then
            if ($urandom_range(0, 99) < 20) begin
               act = ACT_SELECT_SB;
            end else begin
               act = ($urandom_range(0, 99) < lean_off) ? ACT_DISABLE_SB : ACT_ENABLE_SB;
            end
            tgt = ($urandom_range(0, 99) < 92) ? 8'($urandom_range(0, SUBBANDS - 1))
                                               : 8'($urandom_range(SUBBANDS, 255));
         end
         send_request(act, tgt, 1'b0, '0);
         if (act == ACT_RESERVED_5 || act == ACT_RESERVED_6 || act == ACT_RESERVED_7 ||
             ((act == ACT_ENABLE_CH || act == ACT_DISABLE_CH) && tgt >= NUM_CHANNELS)) begin
            ignored_count++;
         end
         n++;
      end
      req_valid <= 1'b0;
      no_idle   <= 1'b0;

      // drain, then give a stray response time to show up
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (SUBBANDS + 8) @(posedge clock);

      $display("covered %0d requests (%0d ignored), %0d responses checked",
               sent_count, ignored_count, checked_count);
      $display("%0d changed, %0d bad band, narrow count seen %0d..%0d, wide %0d..%0d",
               changed_count, bad_band_count, narrow_low, narrow_high, wide_low, wide_high);
      if (error_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
